// ----- hdl/key_to_differential_drive_mixer_unit_defines.svh -----
`ifndef KEY_TO_DIFFERENTIAL_DRIVE_MIXER_UNIT_DEFINES_SVH
`define KEY_TO_DIFFERENTIAL_DRIVE_MIXER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled in reset
`define KDM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kdm checker: implication failed");

// Next-cycle implication, sampled on clk, disabled in reset
`define KDM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kdm checker: next-cycle implication failed");

`endif

// ----- hdl/kdm_pkg.sv -----
`timescale 1ns / 1ps

package kdm_pkg;

    typedef logic [7:0] key_byte_t;
    typedef logic [6:0] duty_t;
    typedef logic [2:0] cfg_index_t;

    localparam key_byte_t KEY_DOWN = 8'hA0;
    localparam key_byte_t KEY_UP   = 8'h05;

    // Register indexes on the configuration channel
    localparam cfg_index_t CFG_BASE_DUTY      = 3'd0;
    localparam cfg_index_t CFG_RAMP_FLOOR     = 3'd1;
    localparam cfg_index_t CFG_RAMP_CEILING   = 3'd2;
    localparam cfg_index_t CFG_RAMP_INCREMENT = 3'd3;
    localparam cfg_index_t CFG_STEER_OFFSET   = 3'd4;
    localparam cfg_index_t CFG_SPIN_DUTY      = 3'd5;

    localparam duty_t RST_BASE_DUTY      = 7'd70;
    localparam duty_t RST_RAMP_FLOOR     = 7'd50;
    localparam duty_t RST_RAMP_CEILING   = 7'd100;
    localparam duty_t RST_RAMP_INCREMENT = 7'd5;
    localparam duty_t RST_STEER_OFFSET   = 7'd10;
    localparam duty_t RST_SPIN_DUTY      = 7'd55;

    typedef struct packed {
        duty_t base_duty;
        duty_t ramp_floor;
        duty_t ramp_ceiling;
        duty_t ramp_increment;
        duty_t steer_offset;
        duty_t spin_duty;
    } cfg_t;

    typedef struct packed {
        key_byte_t key_forward;
        key_byte_t key_left;
        key_byte_t key_back;
        key_byte_t key_right;
        key_byte_t key_faster;
        key_byte_t key_slower;
    } keys_t;

    typedef struct packed {
        logic  left_forward;
        duty_t left_duty;
        logic  right_forward;
        duty_t right_duty;
    } drive_t;

endpackage

// ----- hdl/kdm_key_if.sv -----
`timescale 1ns / 1ps

interface kdm_key_if;
    logic               valid;
    logic               ready;
    kdm_pkg::key_byte_t key_forward;
    kdm_pkg::key_byte_t key_left;
    kdm_pkg::key_byte_t key_back;
    kdm_pkg::key_byte_t key_right;
    kdm_pkg::key_byte_t key_faster;
    kdm_pkg::key_byte_t key_slower;

    modport source (
        output valid, key_forward, key_left, key_back, key_right, key_faster, key_slower,
        input  ready
    );
    modport sink (
        input  valid, key_forward, key_left, key_back, key_right, key_faster, key_slower,
        output ready
    );
endinterface

// ----- hdl/kdm_drive_if.sv -----
`timescale 1ns / 1ps

interface kdm_drive_if;
    logic           valid;
    logic           ready;
    logic           left_forward;
    kdm_pkg::duty_t left_duty;
    logic           right_forward;
    kdm_pkg::duty_t right_duty;

    modport source (
        output valid, left_forward, left_duty, right_forward, right_duty,
        input  ready
    );
    modport sink (
        input  valid, left_forward, left_duty, right_forward, right_duty,
        output ready
    );
endinterface

// ----- hdl/kdm_cfg_if.sv -----
`timescale 1ns / 1ps

interface kdm_cfg_if;
    logic                  valid;
    logic                  ready;
    kdm_pkg::cfg_index_t   index;
    kdm_pkg::duty_t        data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- hdl/kdm_cfg_regs.sv -----
`timescale 1ns / 1ps

module kdm_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    kdm_cfg_if.sink       cfg,
    output kdm_pkg::cfg_t regs
);
    import kdm_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BASE_DUTY:      regs_next.base_duty      = cfg.data;
                CFG_RAMP_FLOOR:     regs_next.ramp_floor     = cfg.data;
                CFG_RAMP_CEILING:   regs_next.ramp_ceiling   = cfg.data;
                CFG_RAMP_INCREMENT: regs_next.ramp_increment = cfg.data;
                CFG_STEER_OFFSET:   regs_next.steer_offset   = cfg.data;
                CFG_SPIN_DUTY:      regs_next.spin_duty      = cfg.data;
                default:            regs_next                = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.base_duty      <= RST_BASE_DUTY;
            regs_reg.ramp_floor     <= RST_RAMP_FLOOR;
            regs_reg.ramp_ceiling   <= RST_RAMP_CEILING;
            regs_reg.ramp_increment <= RST_RAMP_INCREMENT;
            regs_reg.steer_offset   <= RST_STEER_OFFSET;
            regs_reg.spin_duty      <= RST_SPIN_DUTY;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- hdl/kdm_mixer.sv -----
`timescale 1ns / 1ps

module kdm_mixer (
    input  kdm_pkg::keys_t  keys,
    input  kdm_pkg::cfg_t   regs,
    input  kdm_pkg::duty_t  ramp,
    output kdm_pkg::duty_t  ramp_next,
    output kdm_pkg::drive_t drive
);
    import kdm_pkg::*;

    logic       go_fwd;
    logic       go_back;
    logic       driving;
    logic       vert_same;
    logic       steer_l;
    logic       steer_r;
    logic       right_outer;
    logic [7:0] up_sum;
    logic [7:0] floor_sum;
    logic [7:0] hi_sum;
    duty_t      lo_duty;
    logic [7:0] ld_raw;
    logic [7:0] rd_raw;

    function automatic duty_t clamp_duty(input logic [7:0] v, input duty_t ceil);
        return (v > {1'b0, ceil}) ? ceil : v[6:0];
    endfunction

    assign go_fwd    = (keys.key_forward == KEY_DOWN) && (keys.key_back == KEY_UP);
    assign go_back   = (keys.key_forward == KEY_UP) && (keys.key_back == KEY_DOWN);
    assign driving   = go_fwd || go_back;
    assign vert_same = ((keys.key_forward == KEY_UP) && (keys.key_back == KEY_UP)) ||
                       ((keys.key_forward == KEY_DOWN) && (keys.key_back == KEY_DOWN));
    assign steer_l   = (keys.key_left == KEY_DOWN) && (keys.key_right == KEY_UP);
    assign steer_r   = (keys.key_left == KEY_UP) && (keys.key_right == KEY_DOWN);

    assign up_sum    = {1'b0, ramp} + {1'b0, regs.ramp_increment};
    assign floor_sum = {1'b0, regs.ramp_floor} + {1'b0, regs.ramp_increment};

    // Speed-up wins over slow-down when both are held
    always_comb
    begin
        if (!driving)
            ramp_next = regs.base_duty;
        else if (keys.key_faster == KEY_DOWN)
            ramp_next = clamp_duty(up_sum, regs.ramp_ceiling);
        else if (keys.key_slower == KEY_DOWN)
            ramp_next = ({1'b0, ramp} > floor_sum) ? (ramp - regs.ramp_increment)
                                                   : regs.ramp_floor;
        else
            ramp_next = ramp;
    end

    assign hi_sum      = {1'b0, ramp_next} + {1'b0, regs.steer_offset};
    assign lo_duty     = (ramp_next > regs.steer_offset) ? (ramp_next - regs.steer_offset)
                                                         : 7'd0;
    assign right_outer = (steer_l && go_fwd) || (steer_r && go_back);

    always_comb
    begin
        drive.left_forward  = go_fwd;
        drive.right_forward = go_fwd;
        ld_raw = driving ? {1'b0, ramp_next} : 8'd0;
        rd_raw = ld_raw;
        if (vert_same)
        begin
            // in-place turn
            if (steer_l)
            begin
                drive.left_forward  = 1'b0;
                drive.right_forward = 1'b1;
                ld_raw = {1'b0, regs.spin_duty};
                rd_raw = {1'b0, regs.spin_duty};
            end
            else if (steer_r)
            begin
                drive.left_forward  = 1'b1;
                drive.right_forward = 1'b0;
                ld_raw = {1'b0, regs.spin_duty};
                rd_raw = {1'b0, regs.spin_duty};
            end
        end
        else if (driving && (steer_l || steer_r))
        begin
            if (right_outer)
            begin
                rd_raw = hi_sum;
                ld_raw = {1'b0, lo_duty};
            end
            else
            begin
                ld_raw = hi_sum;
                rd_raw = {1'b0, lo_duty};
            end
        end
        drive.left_duty  = clamp_duty(ld_raw, regs.ramp_ceiling);
        drive.right_duty = clamp_duty(rd_raw, regs.ramp_ceiling);
    end

endmodule

// ----- hdl/key_to_differential_drive_mixer_unit.sv -----
`timescale 1ns / 1ps
// Path: key transaction -> input register -> result register -> drive result.
// Throughput: one transaction per cycle while drive.ready holds; the ramp register updates
// as each item moves from the input register into the result register.
// Reset (rst_n, async, active low): both stages empty, ramp level 70, registers to their
// defaults (70, 50, 100, 5, 10, 55).

module key_to_differential_drive_mixer_unit (
    input  logic       clk,
    input  logic       rst_n,
    kdm_key_if.sink    keys,
    kdm_drive_if.source drive,
    kdm_cfg_if.sink    cfg
);
    import kdm_pkg::*;

    cfg_t   regs;
    keys_t  keys_in;
    keys_t  keys_reg;
    drive_t drive_reg;
    drive_t drive_next;
    duty_t  ramp_reg;
    duty_t  ramp_next;
    logic   in_valid_reg;
    logic   in_valid_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   advance;
    logic   accept;

    kdm_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    kdm_mixer u_mix (
        .keys      (keys_reg),
        .regs      (regs),
        .ramp      (ramp_reg),
        .ramp_next (ramp_next),
        .drive     (drive_next)
    );

    assign keys_in.key_forward = keys.key_forward;
    assign keys_in.key_left    = keys.key_left;
    assign keys_in.key_back    = keys.key_back;
    assign keys_in.key_right   = keys.key_right;
    assign keys_in.key_faster  = keys.key_faster;
    assign keys_in.key_slower  = keys.key_slower;

    assign advance    = !out_valid_reg || drive.ready;
    assign keys.ready = !in_valid_reg || advance;
    assign accept     = keys.valid && keys.ready;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ramp_reg      <= RST_BASE_DUTY;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_valid_reg && advance)
                ramp_reg <= ramp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            keys_reg <= keys_in;
        if (in_valid_reg && advance)
            drive_reg <= drive_next;
    end

    assign drive.valid         = out_valid_reg;
    assign drive.left_forward  = drive_reg.left_forward;
    assign drive.left_duty     = drive_reg.left_duty;
    assign drive.right_forward = drive_reg.right_forward;
    assign drive.right_duty    = drive_reg.right_duty;

endmodule

// ----- hdl/kdm_checker.sv -----
`timescale 1ns / 1ps
`include "key_to_differential_drive_mixer_unit_defines.svh"

module kdm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           keys_valid,
    input logic           keys_ready,
    input logic           drive_valid,
    input logic           drive_ready,
    input logic           left_forward,
    input kdm_pkg::duty_t left_duty,
    input logic           right_forward,
    input kdm_pkg::duty_t right_duty
);
    import kdm_pkg::*;

    logic keys_pending;

    assign keys_pending = keys_valid;

    // A stalled result keeps valid and its payload
    `KDM_ASSERT_NEXT(a_out_hold, drive_valid && !drive_ready, drive_valid && $stable(left_forward) && $stable(left_duty) && $stable(right_forward) && $stable(right_duty))

    // With the result register empty the input side never stalls
    `KDM_ASSERT_IMPL(a_ready_when_empty, !drive_valid && keys_pending, keys_ready)

    // Opposite wheel directions only come from an in-place turn: equal duties
    `KDM_ASSERT_IMPL(a_spin_equal, drive_valid && (left_forward != right_forward), left_duty == right_duty)

endmodule

bind key_to_differential_drive_mixer_unit kdm_checker u_kdm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .keys_valid    (keys.valid),
    .keys_ready    (keys.ready),
    .drive_valid   (drive.valid),
    .drive_ready   (drive.ready),
    .left_forward  (drive.left_forward),
    .left_duty     (drive.left_duty),
    .right_forward (drive.right_forward),
    .right_duty    (drive.right_duty)
);

// ----- tb/key_to_differential_drive_mixer_unit_tb.sv -----
`timescale 1ns / 1ps

module key_to_differential_drive_mixer_unit_tb;

    import kdm_pkg::*;

    // index outside the register map, must be ignored
    localparam cfg_index_t CFG_NO_SUCH_REG = 3'd7;
    localparam int HOLD_CYCLES = 150;

    logic clk;
    logic rst_n;

    kdm_key_if   keys_bus ();
    kdm_drive_if drive_bus ();
    kdm_cfg_if   cfg_bus ();

    key_to_differential_drive_mixer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .keys  (keys_bus),
        .drive (drive_bus),
        .cfg   (cfg_bus)
    );

    keys_t  pending_keys[$];
    drive_t expected_drive[$];

    cfg_t   cfg_model;
    duty_t  ramp_now;
    int     mismatches;

    logic   keys_fired;
    logic   drive_fired;
    int     key_gap;
    int     key_gap_max;
    int     sink_gap;
    int     sink_gap_max;
    int     hold_left;
    bit     hold_request;
    keys_t  key_item;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("key_to_differential_drive_mixer_unit test failed");
        $finish;
    end

    // Mixer prediction: updates the ramp and returns the wheel commands
    function automatic drive_t mix_drive(keys_t k);
        bit          go_fwd;
        bit          go_back;
        bit          driving;
        bit          steer_l;
        bit          steer_r;
        bit          right_outer;
        int unsigned ramp;
        int unsigned inc;
        int unsigned floor_v;
        int unsigned ceil_v;
        int unsigned offset;
        int unsigned ld;
        int unsigned rd;
        drive_t      d;
        go_fwd  = (k.key_forward == KEY_DOWN) && (k.key_back == KEY_UP);
        go_back = (k.key_forward == KEY_UP) && (k.key_back == KEY_DOWN);
        driving = go_fwd || go_back;
        steer_l = (k.key_left == KEY_DOWN) && (k.key_right == KEY_UP);
        steer_r = (k.key_left == KEY_UP) && (k.key_right == KEY_DOWN);
        ramp    = ramp_now;
        inc     = cfg_model.ramp_increment;
        floor_v = cfg_model.ramp_floor;
        ceil_v  = cfg_model.ramp_ceiling;
        offset  = cfg_model.steer_offset;

        if (!driving)
            ramp = cfg_model.base_duty;
        else if (k.key_faster == KEY_DOWN)
            ramp = (ramp + inc > ceil_v) ? ceil_v : ramp + inc;
        else if (k.key_slower == KEY_DOWN)
            ramp = (ramp > floor_v + inc) ? ramp - inc : floor_v;
        ramp_now = duty_t'(ramp);
        ramp = ramp_now;

        ld = driving ? ramp : 0;
        rd = ld;
        d.left_forward  = go_fwd;
        d.right_forward = go_fwd;

        if (k.key_forward inside {KEY_UP, KEY_DOWN} && k.key_forward == k.key_back)
        begin
            // in-place turn
            if (steer_l || steer_r)
            begin
                d.left_forward  = steer_r;
                d.right_forward = steer_l;
                ld = cfg_model.spin_duty;
                rd = cfg_model.spin_duty;
            end
        end
        else if (driving && (steer_l || steer_r))
        begin
            right_outer = (steer_l && go_fwd) || (steer_r && go_back);
            if (right_outer)
            begin
                rd = ramp + offset;
                ld = (ramp > offset) ? ramp - offset : 0;
            end
            else
            begin
                ld = ramp + offset;
                rd = (ramp > offset) ? ramp - offset : 0;
            end
        end

        d.left_duty  = duty_t'((ld > ceil_v) ? ceil_v : ld);
        d.right_duty = duty_t'((rd > ceil_v) ? ceil_v : rd);
        return d;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // Monitor: sample every handshake at the rising edge
    always @(posedge clk)
    begin : monitor
        drive_t want;
        keys_t  k;
        keys_fired  <= rst_n && keys_bus.valid && keys_bus.ready;
        drive_fired <= rst_n && drive_bus.valid && drive_bus.ready;
        if (rst_n)
        begin
            if (drive_bus.valid && drive_bus.ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected drive transaction, actual %0d/%0d %0d/%0d",
                             $time, drive_bus.left_forward, drive_bus.left_duty,
                             drive_bus.right_forward, drive_bus.right_duty);
                end
                else
                begin
                    want = expected_drive.pop_front();
                    check_field("left_forward", want.left_forward, drive_bus.left_forward);
                    check_field("left_duty", want.left_duty, drive_bus.left_duty);
                    check_field("right_forward", want.right_forward, drive_bus.right_forward);
                    check_field("right_duty", want.right_duty, drive_bus.right_duty);
                end
            end
            if (keys_bus.valid && keys_bus.ready)
            begin
                k.key_forward = keys_bus.key_forward;
                k.key_left    = keys_bus.key_left;
                k.key_back    = keys_bus.key_back;
                k.key_right   = keys_bus.key_right;
                k.key_faster  = keys_bus.key_faster;
                k.key_slower  = keys_bus.key_slower;
                expected_drive.push_back(mix_drive(k));
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_bus.index)
                    CFG_BASE_DUTY:      cfg_model.base_duty      = cfg_bus.data;
                    CFG_RAMP_FLOOR:     cfg_model.ramp_floor     = cfg_bus.data;
                    CFG_RAMP_CEILING:   cfg_model.ramp_ceiling   = cfg_bus.data;
                    CFG_RAMP_INCREMENT: cfg_model.ramp_increment = cfg_bus.data;
                    CFG_STEER_OFFSET:   cfg_model.steer_offset   = cfg_bus.data;
                    CFG_SPIN_DUTY:      cfg_model.spin_duty      = cfg_bus.data;
                    default: ;
                endcase
            end
        end
    end

    // Key driver: one transaction at a time from pending_keys, random gap after each
    always @(negedge clk)
    begin : key_driver
        bit offer;
        if (rst_n)
        begin
            if (keys_fired)
                key_gap = $urandom_range(0, key_gap_max);
            offer = keys_bus.valid && !keys_fired;
            if (!offer)
            begin
                if (key_gap != 0)
                    key_gap--;
                else if (pending_keys.size() != 0)
                begin
                    key_item = pending_keys.pop_front();
                    offer = 1'b1;
                    keys_bus.key_forward <= key_item.key_forward;
                    keys_bus.key_left    <= key_item.key_left;
                    keys_bus.key_back    <= key_item.key_back;
                    keys_bus.key_right   <= key_item.key_right;
                    keys_bus.key_faster  <= key_item.key_faster;
                    keys_bus.key_slower  <= key_item.key_slower;
                end
            end
            keys_bus.valid <= offer;
        end
    end

    // Drive sink: random stall after each transaction, long hold on request
    always @(negedge clk)
    begin : drive_sink
        bit take;
        if (rst_n)
        begin
            if (drive_fired)
                sink_gap = $urandom_range(0, sink_gap_max);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else if (sink_gap != 0)
            begin
                sink_gap--;
                take = 1'b0;
            end
            else
                take = 1'b1;
            drive_bus.ready <= take;
        end
    end

    function automatic key_byte_t pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return KEY_DOWN;
        if (r < 70)
            return KEY_UP;
        return key_byte_t'($urandom_range(0, 255));
    endfunction

    function automatic int pick_gap_max();
        int unsigned r;
        r = $urandom_range(0, 2);
        return (r == 0) ? 0 : ((r == 1) ? 3 : 17);
    endfunction

    // Runs of forward or backward driving with random steering and modifiers,
    // mixed with in-place turns and plain noise
    task automatic queue_traffic(int n_items);
        keys_t k;
        int    run_len;
        int    motion;
        bit    coast;
        int    queued;
        queued = 0;
        while (queued < n_items)
        begin
            run_len = $urandom_range(1, 14);
            if (run_len > n_items - queued)
                run_len = n_items - queued;
            motion  = $urandom_range(0, 9);
            coast   = $urandom_range(0, 1);
            repeat (run_len)
            begin
                k.key_forward = pick_key();
                k.key_left    = pick_key();
                k.key_back    = pick_key();
                k.key_right   = pick_key();
                k.key_faster  = pick_key();
                k.key_slower  = pick_key();
                if (motion < 4)
                begin
                    k.key_forward = KEY_DOWN;
                    k.key_back    = KEY_UP;
                end
                else if (motion < 7)
                begin
                    k.key_forward = KEY_UP;
                    k.key_back    = KEY_DOWN;
                end
                else if (motion == 7)
                begin
                    k.key_forward = $urandom_range(0, 1) ? KEY_DOWN : KEY_UP;
                    k.key_back    = k.key_forward;
                end
                // let slow-down win for a whole run so the floor gets reached
                if (motion < 7 && coast && k.key_faster == KEY_DOWN)
                    k.key_faster = KEY_UP;
                pending_keys.push_back(k);
                queued++;
            end
        end
    endtask

    // Checked at the rising edge, where the driver's last offer is already visible
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_keys.size() != 0 || keys_bus.valid || expected_drive.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, duty_t value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic load_settings(cfg_t s);
        write_register(CFG_BASE_DUTY, s.base_duty);
        write_register(CFG_RAMP_FLOOR, s.ramp_floor);
        write_register(CFG_RAMP_CEILING, s.ramp_ceiling);
        write_register(CFG_RAMP_INCREMENT, s.ramp_increment);
        write_register(CFG_STEER_OFFSET, s.steer_offset);
        write_register(CFG_SPIN_DUTY, s.spin_duty);
    endtask

    function automatic cfg_t settings_for(int phase);
        cfg_t s;
        int   top;
        top = (phase < 7) ? 100 : 127;
        s.base_duty      = duty_t'($urandom_range(0, top));
        s.ramp_floor     = duty_t'($urandom_range(0, top));
        s.ramp_ceiling   = duty_t'($urandom_range(0, top));
        s.ramp_increment = duty_t'($urandom_range(0, 30));
        s.steer_offset   = duty_t'($urandom_range(0, top));
        s.spin_duty      = duty_t'($urandom_range(0, top));
        case (phase)
            1: s = '0;
            3: s = {6{7'd100}};
            4: s = {6{7'd127}};
            5:
            begin
                // low ceiling clamps ramp, spin and outer wheel; big offset saturates inner
                s.base_duty      = 7'd90;
                s.ramp_floor     = 7'd20;
                s.ramp_ceiling   = 7'd40;
                s.ramp_increment = 7'd30;
                s.steer_offset   = 7'd100;
                s.spin_duty      = 7'd100;
            end
            6:
            begin
                // floor above ceiling
                s.base_duty      = 7'd10;
                s.ramp_floor     = 7'd100;
                s.ramp_ceiling   = 7'd30;
                s.ramp_increment = 7'd127;
                s.steer_offset   = 7'd127;
                s.spin_duty      = 7'd0;
            end
            default: ;
        endcase
        return s;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        keys_bus.valid       = 1'b0;
        keys_bus.key_forward = '0;
        keys_bus.key_left    = '0;
        keys_bus.key_back    = '0;
        keys_bus.key_right   = '0;
        keys_bus.key_faster  = '0;
        keys_bus.key_slower  = '0;
        drive_bus.ready      = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = CFG_BASE_DUTY;
        cfg_bus.data         = '0;
        cfg_model.base_duty      = RST_BASE_DUTY;
        cfg_model.ramp_floor     = RST_RAMP_FLOOR;
        cfg_model.ramp_ceiling   = RST_RAMP_CEILING;
        cfg_model.ramp_increment = RST_RAMP_INCREMENT;
        cfg_model.steer_offset   = RST_STEER_OFFSET;
        cfg_model.spin_duty      = RST_SPIN_DUTY;
        ramp_now     = RST_BASE_DUTY;
        mismatches   = 0;
        keys_fired   = 1'b0;
        drive_fired  = 1'b0;
        key_gap      = 0;
        key_gap_max  = 0;
        sink_gap     = 0;
        sink_gap_max = 0;
        hold_left    = 0;
        hold_request = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset settings
        pending_keys.push_back(keys_t'({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}));
        pending_keys.push_back(keys_t'({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}));
        pending_keys.push_back(keys_t'({KEY_DOWN, 8'h00, KEY_UP, 8'h00, 8'h00, 8'h00}));
        pending_keys.push_back(keys_t'({KEY_DOWN, 8'h00, KEY_UP, 8'h00, KEY_DOWN, 8'h00}));
        // both modifiers: speed-up wins
        pending_keys.push_back(keys_t'({KEY_DOWN, 8'h00, KEY_UP, 8'h00, KEY_DOWN, KEY_DOWN}));
        pending_keys.push_back(keys_t'({KEY_UP, 8'h00, KEY_DOWN, 8'h00, KEY_UP, KEY_DOWN}));
        pending_keys.push_back(keys_t'({KEY_UP, 8'h00, KEY_DOWN, 8'h00, KEY_UP, KEY_DOWN}));
        // moving turns, all four combinations
        pending_keys.push_back(keys_t'({KEY_DOWN, KEY_DOWN, KEY_UP, KEY_UP, 8'h00, 8'h00}));
        pending_keys.push_back(keys_t'({KEY_DOWN, KEY_UP, KEY_UP, KEY_DOWN, 8'h00, 8'h00}));
        pending_keys.push_back(keys_t'({KEY_UP, KEY_DOWN, KEY_DOWN, KEY_UP, 8'h00, 8'h00}));
        pending_keys.push_back(keys_t'({KEY_UP, KEY_UP, KEY_DOWN, KEY_DOWN, 8'h00, 8'h00}));
        // in-place turns, verticals both released and both pressed
        pending_keys.push_back(keys_t'({KEY_UP, KEY_DOWN, KEY_UP, KEY_UP, 8'h00, 8'h00}));
        pending_keys.push_back(keys_t'({KEY_UP, KEY_UP, KEY_UP, KEY_DOWN, 8'h00, 8'h00}));
        pending_keys.push_back(keys_t'({KEY_DOWN, KEY_DOWN, KEY_DOWN, KEY_UP, 8'h00, 8'h00}));
        pending_keys.push_back(keys_t'({KEY_DOWN, KEY_UP, KEY_DOWN, KEY_DOWN, 8'h00, 8'h00}));
        pending_keys.push_back(keys_t'({KEY_DOWN, 8'h00, KEY_DOWN, 8'h00, KEY_DOWN, 8'h00}));
        // steer keys not a valid pair: no turn
        pending_keys.push_back(keys_t'({KEY_DOWN, KEY_DOWN, KEY_UP, KEY_DOWN, 8'h00, 8'h00}));
        pending_keys.push_back(keys_t'({KEY_DOWN, KEY_DOWN, KEY_UP, 8'h33, 8'h00, 8'h00}));
        pending_keys.push_back(keys_t'({KEY_UP, KEY_DOWN, KEY_UP, KEY_DOWN, KEY_DOWN, 8'h00}));
        // undefined vertical bytes
        pending_keys.push_back(keys_t'({8'hA1, KEY_DOWN, KEY_UP, KEY_UP, KEY_DOWN, 8'h00}));
        pending_keys.push_back(keys_t'({KEY_DOWN, KEY_UP, 8'h04, KEY_DOWN, 8'h00, KEY_DOWN}));
        pending_keys.push_back(keys_t'({8'h5F, KEY_DOWN, 8'hFA, KEY_UP, 8'h00, 8'h00}));
        wait_idle();

        for (int phase = 0; phase < 9; phase++)
        begin
            load_settings(settings_for(phase));
            if (phase == 0)
                write_register(CFG_NO_SUCH_REG, duty_t'($urandom_range(0, 127)));
            key_gap_max  = pick_gap_max();
            sink_gap_max = pick_gap_max();
            if (phase == 1)
            begin
                key_gap_max  = 0;
                sink_gap_max = 0;
            end
            if (phase == 2)
            begin
                // sink stalls for a long stretch while keys keep coming
                key_gap_max = 0;
                queue_traffic(60);
                hold_request = 1'b1;
            end
            else if (phase == 7)
            begin
                queue_traffic(30);
                wait_idle();
                queue_traffic(30);
            end
            else
                queue_traffic(60);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_drive.size() == 0)
            $display("key_to_differential_drive_mixer_unit test passed");
        else
            $display("key_to_differential_drive_mixer_unit test failed");
        $finish;
    end

endmodule
